// ----- sv/svvt_pkg.sv -----
// shared types and constants for the sorted versioned value table
`default_nettype none

package svvt_pkg;

  localparam int SVVT_TABLE_DEPTH = 16;
  localparam int SVVT_KEY_W       = 16;
  localparam int SVVT_VAL_W       = 32;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_FLOOR = 2'd1;
  localparam logic [1:0] CMD_EXACT = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [SVVT_KEY_W-1:0] version_key;
    logic [SVVT_VAL_W-1:0] entry_value;
  } svvt_in_t;

  typedef struct packed {
    logic                  hit;
    logic [SVVT_KEY_W-1:0] found_key;
    logic [SVVT_VAL_W-1:0] found_value;
    logic                  table_full;
  } svvt_out_t;

  typedef struct packed {
    logic                  valid;
    logic [SVVT_KEY_W-1:0] key;
    logic [SVVT_VAL_W-1:0] value;
  } svvt_rec_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                  accept;
    logic [1:0]            cmd;
    logic [SVVT_KEY_W-1:0] key;
    logic [SVVT_VAL_W-1:0] value;
    logic                  ins;
    logic                  ovr;
  } svvt_bcast_t;

endpackage

`default_nettype wire

// ----- sv/svvt_cell.sv -----
// one record cell of the sorted table row with its result carry stage
`default_nettype none

module svvt_cell
  import svvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire svvt_bcast_t bcast,
  input  wire logic        left_le,
  input  wire svvt_rec_t   left_rec,
  input  wire logic        right_le,
  input  wire svvt_rec_t   carry_in,
  output logic             le,
  output logic             match,
  output svvt_rec_t        rec,
  output svvt_rec_t        carry_out
);

  logic                  valid_r;
  logic [SVVT_KEY_W-1:0] key_r;
  logic [SVVT_VAL_W-1:0] value_r;
  logic                  sel_r;
  logic                  sel_nxt;
  svvt_rec_t             carry_r;
  logic                  bound;
  logic                  is_set;

  assign le     = valid_r && (key_r <= bcast.key);
  assign bound  = le && !right_le;
  assign match  = bound && (key_r == bcast.key);
  assign is_set = bcast.accept && (bcast.cmd == CMD_SET);

  assign rec       = '{valid: valid_r, key: key_r, value: value_r};
  assign carry_out = carry_r;

  // this cell holds the answer of a lookup
  always_comb begin
    sel_nxt = sel_r;
    if (bcast.accept) begin
      sel_nxt = ((bcast.cmd == CMD_FLOOR) && bound) ||
                ((bcast.cmd == CMD_EXACT) && match);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (is_set && bcast.ovr && match) begin
        value_r <= bcast.value;
      end
      // insert: the slot at the insert point takes the new record, those
      // above it take their left neighbor's record
      if (is_set && bcast.ins && !le) begin
        if (left_le) begin
          valid_r <= 1'b1;
          key_r   <= bcast.key;
          value_r <= bcast.value;
        end else begin
          valid_r <= left_rec.valid;
          key_r   <= left_rec.key;
          value_r <= left_rec.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= sel_r ? rec : carry_in;
  end

endmodule

`default_nettype wire

// ----- sv/svvt_out_buf.sv -----
// output register with one hold stage for the result channel
`default_nettype none

module svvt_out_buf
  import svvt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire svvt_out_t res_data,
  input  wire logic      out_stall,
  output logic           out_valid,
  output svvt_out_t      out_data,
  output logic           hold_busy
);

  logic      out_v_r;
  logic      out_v_nxt;
  svvt_out_t out_d_r;
  svvt_out_t out_d_nxt;
  logic      hold_v_r;
  logic      hold_v_nxt;
  svvt_out_t hold_d_r;
  svvt_out_t hold_d_nxt;
  logic      slot_free;

  assign slot_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    hold_v_nxt = hold_v_r;
    hold_d_nxt = hold_d_r;
    if (slot_free) begin
      if (hold_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = hold_d_r;
        hold_v_nxt = res_valid;
        hold_d_nxt = res_data;
      end else begin
        out_v_nxt = res_valid;
        out_d_nxt = res_data;
      end
    end else if (res_valid) begin
      hold_v_nxt = 1'b1;
      hold_d_nxt = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    hold_d_r <= hold_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;
  assign hold_busy = hold_v_r;

endmodule

`default_nettype wire

// ----- sv/sorted_versioned_value_table_top.sv -----
// top level of the sorted versioned value table: cell row, sequencer, output buffer
//
//   channel | ports                           | direction | item
//   --------+---------------------------------+-----------+------------------------------
//   input   | in_valid, in_stall, in_data     | in        | cmd, version_key, entry_value
//   result  | out_valid, out_stall, out_data  | out       | hit, found_key, found_value,
//           |                                 |           | table_full
//
// a set item: every cell compares its key with the item's key and the row
// overwrites a matching record, or shifts up and inserts when the table is not full
// in a lookup item the selected record travels the result carry chain one cell
// per cycle before it reaches the output
// reset leaves the table empty; cell valid bits clear at once
// the input stalls during a lookup and while a result sits in the hold stage

`default_nettype none

module sorted_versioned_value_table_top
  import svvt_pkg::*;
#(
  parameter int TABLE_DEPTH = SVVT_TABLE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire svvt_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output svvt_out_t      out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH);

  // row wiring
  logic [TABLE_DEPTH-1:0] le_w;
  logic [TABLE_DEPTH-1:0] match_w;
  svvt_rec_t              rec_w   [TABLE_DEPTH];
  svvt_rec_t              carry_w [TABLE_DEPTH];

  svvt_bcast_t bcast;
  logic        accept;
  logic        hold_busy;
  logic        any_match;
  logic        full;

  // lookup sequencer
  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic      res_valid;
  svvt_out_t res_data;

  assign in_stall = busy_r || hold_busy;
  assign accept   = in_valid && !in_stall;

  // a match can only sit in the boundary cell, so the or has one bit set at most
  assign any_match = |match_w;
  assign full      = rec_w[TABLE_DEPTH-1].valid;

  assign bcast.accept = accept;
  assign bcast.cmd    = in_data.cmd;
  assign bcast.key    = in_data.version_key;
  assign bcast.value  = in_data.entry_value;
  assign bcast.ovr    = 1'b1;
  assign bcast.ins    = !any_match && !full;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic      left_le;
      svvt_rec_t left_rec;
      logic      right_le;
      svvt_rec_t carry_in;

      if (gi == 0) begin : g_first
        // left edge: insert point when every record is above the key
        assign left_le  = 1'b1;
        assign left_rec = '0;
        assign carry_in = '0;
      end else begin : g_inner
        assign left_le  = le_w[gi-1];
        assign left_rec = rec_w[gi-1];
        assign carry_in = carry_w[gi-1];
      end

      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign right_le = 1'b0;
      end else begin : g_mid
        assign right_le = le_w[gi+1];
      end

      svvt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bcast     (bcast),
        .left_le   (left_le),
        .left_rec  (left_rec),
        .right_le  (right_le),
        .carry_in  (carry_in),
        .le        (le_w[gi]),
        .match     (match_w[gi]),
        .rec       (rec_w[gi]),
        .carry_out (carry_w[gi])
      );
    end
  endgenerate

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept && (in_data.cmd != CMD_SET)) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result: set answers at once, a lookup when the carry has left the last cell
  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    if (accept && (in_data.cmd == CMD_SET)) begin
      res_valid = 1'b1;
      if (any_match || !full) begin
        res_data.hit         = 1'b1;
        res_data.found_key   = in_data.version_key;
        res_data.found_value = in_data.entry_value;
      end else begin
        res_data.table_full = 1'b1;
      end
    end else if (busy_r && (cnt_r == CNT_LAST)) begin
      res_valid            = 1'b1;
      res_data.hit         = carry_w[TABLE_DEPTH-1].valid;
      res_data.found_key   = carry_w[TABLE_DEPTH-1].key;
      res_data.found_value = carry_w[TABLE_DEPTH-1].value;
    end
  end

  svvt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .hold_busy (hold_busy)
  );

endmodule

`default_nettype wire

// ----- sv/svvt_checker.sv -----
// port-level checks for the sorted versioned value table, bound to the top level
`default_nettype none

module svvt_checker
  import svvt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire svvt_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire svvt_out_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.table_full))
    else $error("refused set reported as hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> (out_data.found_key == '0) && (out_data.found_value == '0))
    else $error("miss carries nonzero record");

  // a lookup walks the carry chain, so the input closes right after it
  a_lookup_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd != CMD_SET) |=> in_stall)
    else $error("input open right after a lookup item");

endmodule

bind sorted_versioned_value_table_top svvt_checker u_svvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
